@@ design/cco_pkg.sv @@
// ----------------------------------------------------------------------------
// cco_pkg - shared types and constants for the capsule overlap pipeline
// Beat layouts, fixed field widths and the small code sets used by the
// datapath and the divider.
// ----------------------------------------------------------------------------
package cco_pkg;

  localparam int POINT_BITS     = 63;
  localparam int RAD_BITS       = 20;
  localparam int COORD_BITS_DEF = 21;
  localparam int SPAR_BITS      = 24;
  localparam int PAR_SHIFT      = 20;

  typedef struct packed {
    logic [POINT_BITS-1:0] seg1_start;
    logic [POINT_BITS-1:0] seg1_end;
    logic [POINT_BITS-1:0] seg2_start;
    logic [POINT_BITS-1:0] seg2_end;
    logic [RAD_BITS-1:0]   radius_one;
    logic [RAD_BITS-1:0]   radius_two;
  } query_t;

  typedef struct packed {
    logic overlap;
  } answer_t;

  // quantiser mode
  typedef logic [1:0] qmode_t;
  localparam qmode_t QM_DIV  = 2'd0;
  localparam qmode_t QM_ZERO = 2'd1;
  localparam qmode_t QM_FULL = 2'd2;

  // where a ratio lies against [0,1]
  typedef logic [1:0] side_t;
  localparam side_t SD_IN = 2'd0;
  localparam side_t SD_LO = 2'd1;
  localparam side_t SD_HI = 2'd2;

endpackage

@@ design/cco_if.sv @@
// ----------------------------------------------------------------------------
// cco_if - valid/ready channels for query and answer beats
// One interface per direction, each with source and sink views.
// ----------------------------------------------------------------------------
interface cco_query_if import cco_pkg::*; ();
  logic   valid;
  logic   ready;
  query_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cco_result_if import cco_pkg::*; ();
  logic    valid;
  logic    ready;
  answer_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ design/cco_mul.sv @@
// ----------------------------------------------------------------------------
// cco_mul - two-stage signed multiplier
// Magnitudes split in halves; four partial products registered, then summed
// and signed in the second stage.
// ----------------------------------------------------------------------------
module cco_mul #(
  parameter int AW = 46,
  parameter int BW = 46
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [AW-1:0]  a,
  input  logic signed [BW-1:0]  b,
  output logic signed [AW+BW-1:0] p
);

  localparam int AL = AW / 2;
  localparam int AH = AW - AL;
  localparam int BL = BW / 2;
  localparam int BH = BW - BL;
  localparam int PW = AW + BW;

  logic [AW-1:0] ma;
  logic [BW-1:0] mb;
  logic [AL+BL-1:0] p00;
  logic [AL+BH-1:0] p01;
  logic [AH+BL-1:0] p10;
  logic [AH+BH-1:0] p11;
  logic neg;
  logic [PW-1:0] sum;

  assign ma = a[AW-1] ? (~a + 1'b1) : a;
  assign mb = b[BW-1] ? (~b + 1'b1) : b;

  always_ff @(posedge clk) begin
    if (en) begin
      p00 <= ma[AL-1:0] * mb[BL-1:0];
      p01 <= ma[AL-1:0] * mb[BW-1:BL];
      p10 <= ma[AW-1:AL] * mb[BL-1:0];
      p11 <= ma[AW-1:AL] * mb[BW-1:BL];
      neg <= a[AW-1] ^ b[BW-1];
    end
  end

  assign sum = PW'(p00) + (PW'(p01) << BL) + (PW'(p10) << AL) + (PW'(p11) << (AL + BL));

  always_ff @(posedge clk) begin
    if (en) begin
      p <= neg ? (~sum + 1'b1) : sum;
    end
  end

endmodule

@@ design/cco_div.sv @@
// ----------------------------------------------------------------------------
// cco_div - pipelined restoring divider for segment parameters
// One quotient bit per stage; gives floor(num * 2^QB / den) for num < den,
// or the saturated value chosen by the mode.
// ----------------------------------------------------------------------------
module cco_div import cco_pkg::*; #(
  parameter int NW = 95,
  parameter int QB = SPAR_BITS
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [NW-1:0] den,
  input  qmode_t        mode,
  output logic [QB:0]   quo
);

  logic [NW-1:0] rem [QB];
  logic [NW-1:0] dv  [QB];
  logic [QB-1:0] qv  [QB];
  qmode_t        md  [QB];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [NW-1:0] rem_in;
    logic [NW-1:0] den_in;
    logic [QB-1:0] q_in;
    qmode_t        md_in;
    logic [NW:0]   sh;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign q_in   = '0;
      assign md_in  = mode;
    end else begin : g_next
      assign rem_in = rem[k-1];
      assign den_in = dv[k-1];
      assign q_in   = qv[k-1];
      assign md_in  = md[k-1];
    end

    assign sh = {rem_in, 1'b0};
    assign ge = sh >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? NW'(sh - {1'b0, den_in}) : NW'(sh);
        dv[k]  <= den_in;
        qv[k]  <= {q_in[QB-2:0], ge};
        md[k]  <= md_in;
      end
    end
  end

  always_comb begin
    case (md[QB-1])
      QM_ZERO: quo = '0;
      QM_FULL: quo = (QB+1)'(1) << QB;
      default: quo = {1'b0, qv[QB-1]};
    endcase
  end

endmodule

@@ design/capsule_capsule_overlap.sv @@
// Throughput: one query per cycle unless the answer stalls; the 24-stage
// divider pair and two-stage multipliers all take a new operand every cycle.
// A stalled answer freezes the whole pipeline; nothing is dropped or repeated.
// Reset (rst, synchronous) clears the valid bits only; datapath is not reset.
// ----------------------------------------------------------------------------
// capsule_capsule_overlap - capsule versus capsule overlap test
// Closest points of two segments with clamping, then squared distance against
// squared radius sum, in exact fixed point.
// ----------------------------------------------------------------------------
module capsule_capsule_overlap import cco_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  cco_query_if.sink     query,
  cco_result_if.source  answer
);

  localparam int DLW  = COORD_BITS + 1;
  localparam int PRW  = 2 * DLW;
  localparam int DW   = PRW + 2;
  localparam int PW   = 2 * DW;
  localparam int NW   = PW + 1;
  localparam int XW   = NW + PAR_SHIFT;
  localparam int QW   = SPAR_BITS + 1;
  localparam int QPW  = QW + 1 + DLW;
  localparam int KW   = QPW + 2;
  localparam int SQW  = 2 * KW;
  localparam int SW   = SQW + 2;
  localparam int RSW  = RAD_BITS + 1;
  localparam int LMW  = 2 * RSW;
  localparam int LSW  = LMW + 2 * SPAR_BITS;
  localparam int CW   = ((SW > LSW) ? SW : LSW) + 1;
  localparam int LAT  = 16 + SPAR_BITS;
  localparam int GEO_LEN = SPAR_BITS + 10;
  localparam int DOT_LEN = 6;

  typedef struct packed {
    logic [2:0][DLW-1:0] d1;
    logic [2:0][DLW-1:0] d2;
    logic [2:0][DLW-1:0] r;
    logic [RSW-1:0]      rs;
  } geo_t;

  typedef struct packed {
    logic [2:0][PRW-1:0] aa;
    logic [2:0][PRW-1:0] ee;
    logic [2:0][PRW-1:0] bb;
    logic [2:0][PRW-1:0] cc;
    logic [2:0][PRW-1:0] ff;
  } prod_t;

  typedef struct packed {
    logic signed [DW-1:0] a;
    logic signed [DW-1:0] b;
    logic signed [DW-1:0] c;
    logic signed [DW-1:0] e;
    logic signed [DW-1:0] f;
  } dot_t;

  typedef struct packed {
    logic signed [NW-1:0] n;
    logic signed [NW-1:0] d;
  } rat_t;

  function automatic logic signed [DLW-1:0] crd(input logic [POINT_BITS-1:0] v,
                                                 input int k);
    crd = DLW'($signed(v[k*COORD_BITS +: COORD_BITS]));
  endfunction

  function automatic side_t side_of(input rat_t q);
    if (q.d == '0) begin
      side_of = SD_IN;
    end else if (q.n < 0) begin
      side_of = SD_LO;
    end else if (q.d < q.n) begin
      side_of = SD_HI;
    end else begin
      side_of = SD_IN;
    end
  endfunction

  function automatic qmode_t mode_of(input rat_t q);
    if (q.d == '0 || q.n < 0) begin
      mode_of = QM_ZERO;
    end else if (q.n >= q.d) begin
      mode_of = QM_FULL;
    end else begin
      mode_of = QM_DIV;
    end
  endfunction

  logic [LAT-1:0] vld;
  logic           en;

  geo_t geo_next;
  geo_t gd [GEO_LEN];
  prod_t prd;
  dot_t  dot_next;
  dot_t  dt [DOT_LEN];

  logic signed [PW-1:0] ae5, bb5, bf5, ce5, af5, bc5;
  logic signed [PW-1:0] ae6;
  logic signed [NW-1:0] den6, sn6, tn6;

  rat_t s7, t7, s7_next, t7_next;
  rat_t s8, t8, s8_next, t8_next;
  rat_t s9, t9, s9_next, t9_next;
  logic near7;
  side_t sd8, sd9;

  logic [NW-1:0] sn10, sd10, tn10, td10;
  qmode_t sm10, tm10;
  logic [QW-1:0] quo_s, quo_t;

  logic [2:0][QPW-1:0] ps35, pt35;
  logic [2:0][DLW-1:0] r35;
  logic [LMW-1:0] lim35, lim36, lim37, lim38, lim39;
  logic [2:0][KW-1:0] dk36;
  logic signed [SQW-1:0] sq0, sq1, sq2;
  logic [SW-1:0] sum39;

  assign en          = !vld[LAT-1] || answer.ready;
  assign query.ready = en;
  assign answer.valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], query.valid};
    end
  end

  // stage 1: direction vectors and radius sum
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      geo_next.d1[k] = crd(query.data.seg1_end, k) - crd(query.data.seg1_start, k);
      geo_next.d2[k] = crd(query.data.seg2_end, k) - crd(query.data.seg2_start, k);
      geo_next.r[k]  = crd(query.data.seg1_start, k) - crd(query.data.seg2_start, k);
    end
    geo_next.rs = RSW'(query.data.radius_one) + RSW'(query.data.radius_two);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gd[0] <= geo_next;
      for (int i = 1; i < GEO_LEN; i++) begin
        gd[i] <= gd[i-1];
      end
    end
  end

  // stage 2: per-axis products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        prd.aa[k] <= $signed(gd[0].d1[k]) * $signed(gd[0].d1[k]);
        prd.ee[k] <= $signed(gd[0].d2[k]) * $signed(gd[0].d2[k]);
        prd.bb[k] <= $signed(gd[0].d1[k]) * $signed(gd[0].d2[k]);
        prd.cc[k] <= $signed(gd[0].d1[k]) * $signed(gd[0].r[k]);
        prd.ff[k] <= $signed(gd[0].d2[k]) * $signed(gd[0].r[k]);
      end
    end
  end

  // stage 3: dot products
  always_comb begin
    dot_next.a = DW'($signed(prd.aa[0])) + DW'($signed(prd.aa[1])) + DW'($signed(prd.aa[2]));
    dot_next.e = DW'($signed(prd.ee[0])) + DW'($signed(prd.ee[1])) + DW'($signed(prd.ee[2]));
    dot_next.b = DW'($signed(prd.bb[0])) + DW'($signed(prd.bb[1])) + DW'($signed(prd.bb[2]));
    dot_next.c = DW'($signed(prd.cc[0])) + DW'($signed(prd.cc[1])) + DW'($signed(prd.cc[2]));
    dot_next.f = DW'($signed(prd.ff[0])) + DW'($signed(prd.ff[1])) + DW'($signed(prd.ff[2]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dt[0] <= dot_next;
      for (int i = 1; i < DOT_LEN; i++) begin
        dt[i] <= dt[i-1];
      end
    end
  end

  // stages 4-5: cross products
  cco_mul #(.AW(DW), .BW(DW)) u_mul_ae (.clk, .en, .a(dt[0].a), .b(dt[0].e), .p(ae5));
  cco_mul #(.AW(DW), .BW(DW)) u_mul_bb (.clk, .en, .a(dt[0].b), .b(dt[0].b), .p(bb5));
  cco_mul #(.AW(DW), .BW(DW)) u_mul_bf (.clk, .en, .a(dt[0].b), .b(dt[0].f), .p(bf5));
  cco_mul #(.AW(DW), .BW(DW)) u_mul_ce (.clk, .en, .a(dt[0].c), .b(dt[0].e), .p(ce5));
  cco_mul #(.AW(DW), .BW(DW)) u_mul_af (.clk, .en, .a(dt[0].a), .b(dt[0].f), .p(af5));
  cco_mul #(.AW(DW), .BW(DW)) u_mul_bc (.clk, .en, .a(dt[0].b), .b(dt[0].c), .p(bc5));

  // stage 6: denominator and numerators
  always_ff @(posedge clk) begin
    if (en) begin
      ae6  <= ae5;
      den6 <= NW'(ae5) - NW'(bb5);
      sn6  <= NW'(bf5) - NW'(ce5);
      tn6  <= NW'(af5) - NW'(bc5);
    end
  end

  // stage 7: pick the case (near parallel, degenerate, general)
  always_comb begin
    near7 = (ae6 != '0) && ((XW'(den6) <<< PAR_SHIFT) < XW'(ae6));
    if (near7 || dt[3].a == '0) begin
      s7_next = '{n: '0, d: NW'(1)};
      t7_next = '{n: NW'(dt[3].f), d: NW'(dt[3].e)};
    end else if (dt[3].e == '0) begin
      s7_next = '{n: -NW'(dt[3].c), d: NW'(dt[3].a)};
      t7_next = '{n: '0, d: NW'(1)};
    end else begin
      s7_next = '{n: sn6, d: den6};
      t7_next = '{n: tn6, d: den6};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7 <= s7_next;
      t7 <= t7_next;
    end
  end

  // stage 8: clamp s, recompute t
  always_comb begin
    sd8     = side_of(s7);
    s8_next = s7;
    t8_next = t7;
    if (sd8 != SD_IN) begin
      s8_next = '{n: (sd8 == SD_HI) ? NW'(1) : '0, d: NW'(1)};
      t8_next = '{n: NW'(dt[4].f) + ((sd8 == SD_HI) ? NW'(dt[4].b) : '0),
                  d: NW'(dt[4].e)};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s8 <= s8_next;
      t8 <= t8_next;
    end
  end

  // stage 9: clamp t, recompute s (s clamped again by the quantiser)
  always_comb begin
    sd9     = side_of(t8);
    s9_next = s8;
    t9_next = t8;
    if (sd9 != SD_IN) begin
      t9_next = '{n: (sd9 == SD_HI) ? NW'(1) : '0, d: NW'(1)};
      s9_next = '{n: ((sd9 == SD_HI) ? NW'(dt[5].b) : '0) - NW'(dt[5].c),
                  d: NW'(dt[5].a)};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s9 <= s9_next;
      t9 <= t9_next;
    end
  end

  // stage 10: quantiser mode
  always_ff @(posedge clk) begin
    if (en) begin
      sn10 <= s9.n;
      sd10 <= s9.d;
      sm10 <= mode_of(s9);
      tn10 <= t9.n;
      td10 <= t9.d;
      tm10 <= mode_of(t9);
    end
  end

  // stages 11-34: s and t to unsigned Q1.24
  cco_div #(.NW(NW), .QB(SPAR_BITS)) u_div_s (
    .clk, .en, .num(sn10), .den(sd10), .mode(sm10), .quo(quo_s)
  );
  cco_div #(.NW(NW), .QB(SPAR_BITS)) u_div_t (
    .clk, .en, .num(tn10), .den(td10), .mode(tm10), .quo(quo_t)
  );

  // stage 35: parameter times direction, radius sum squared
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        ps35[k] <= $signed({1'b0, quo_s}) * $signed(gd[GEO_LEN-1].d1[k]);
        pt35[k] <= $signed({1'b0, quo_t}) * $signed(gd[GEO_LEN-1].d2[k]);
      end
      r35   <= gd[GEO_LEN-1].r;
      lim35 <= gd[GEO_LEN-1].rs * gd[GEO_LEN-1].rs;
    end
  end

  // stage 36: separation per axis, scaled by 2^24
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        dk36[k] <= (KW'($signed(r35[k])) <<< SPAR_BITS) + KW'($signed(ps35[k]))
                 - KW'($signed(pt35[k]));
      end
      lim36 <= lim35;
    end
  end

  // stages 37-38: squares
  cco_mul #(.AW(KW), .BW(KW)) u_sq_x (.clk, .en, .a($signed(dk36[0])), .b($signed(dk36[0])),
                                      .p(sq0));
  cco_mul #(.AW(KW), .BW(KW)) u_sq_y (.clk, .en, .a($signed(dk36[1])), .b($signed(dk36[1])),
                                      .p(sq1));
  cco_mul #(.AW(KW), .BW(KW)) u_sq_z (.clk, .en, .a($signed(dk36[2])), .b($signed(dk36[2])),
                                      .p(sq2));

  // stages 39-40: sum and compare
  always_ff @(posedge clk) begin
    if (en) begin
      lim37 <= lim36;
      lim38 <= lim37;
      lim39 <= lim38;
      sum39 <= SW'(sq0) + SW'(sq1) + SW'(sq2);
      answer.data.overlap <= CW'(sum39) < (CW'(lim39) << (2 * SPAR_BITS));
    end
  end

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !answer.valid)
    else $error("answer valid straight after reset");

  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("valid pipe moved while stalled");

  a_s_range: assert property (@(posedge clk) disable iff (rst)
    vld[GEO_LEN-1] |-> quo_s <= (QW'(1) << SPAR_BITS))
    else $error("s parameter out of range");

  a_t_range: assert property (@(posedge clk) disable iff (rst)
    vld[GEO_LEN-1] |-> quo_t <= (QW'(1) << SPAR_BITS))
    else $error("t parameter out of range");
`endif

endmodule
